// ===== hw/rtl/tga_pkg.sv =====
// shared types and constants for the tga run-length pixel decoder
// no dependencies; used by every module of the block
package tga_pkg;

    localparam int unsigned DIM_W   = 16;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned STAT_W  = 2;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BPP    = 2'd2;
    localparam logic [1:0] REG_ORIGIN = 2'd3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd1;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd1;
    localparam logic [BPP_W-1:0] BPP_RESET    = 3'd4;
    localparam logic [BPP_W-1:0] BPP_ALPHA    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PIXEL   = 2'd0;
    localparam logic [STAT_W-1:0] ST_EARLY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_RUNPIX,
        PH_RUN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RUN_REQ,
        KIND_BYTE,
        KIND_LAST_BYTE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [BPP_W-1:0] bytes_per_pixel;
        logic             top_origin;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   row;
        logic [DIM_W-1:0]   col;
        logic [STAT_W-1:0]  status;
        logic               done;
    } result_t;

endpackage

// ===== hw/rtl/tga_front.sv =====
// front end: classifies incoming words and holds them in a two-entry queue
// depends on tga_pkg
module tga_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    input  logic [7:0]      s_byte,
    input  logic            s_last,
    output logic            q_valid,
    input  logic            q_ready,
    output tga_pkg::item_t  q_item
);

    tga_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;
    tga_pkg::item_t item_in;

    always_comb
    begin
        item_in.data_byte = s_byte;
        if (s_func)
        begin
            item_in.kind = tga_pkg::KIND_RUN_REQ;
        end
        else if (s_last)
        begin
            item_in.kind = tga_pkg::KIND_LAST_BYTE;
        end
        else
        begin
            item_in.kind = tga_pkg::KIND_BYTE;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== hw/rtl/tga_back.sv =====
// back end: packet decoder, pixel assembly and raster position tracking
// depends on tga_pkg
module tga_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tga_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  tga_pkg::item_t    q_item,
    output logic              res_valid,
    input  logic              res_ready,
    output tga_pkg::result_t  res
);

    tga_pkg::phase_t  phase_reg;
    tga_pkg::phase_t  phase_next;
    logic [7:0]       left_reg;
    logic [7:0]       left_next;
    logic [1:0]       bpos_reg;
    logic [1:0]       bpos_next;
    logic [7:0]       pix_reg [3];
    logic [7:0]       pix_next [3];
    logic [31:0]      run_color_reg;
    logic [31:0]      run_color_next;
    logic [15:0]      col_reg;
    logic [15:0]      col_next;
    logic [15:0]      row_reg;
    logic [15:0]      row_next;
    logic             res_valid_reg;
    tga_pkg::result_t res_reg;
    tga_pkg::result_t res_comb;

    logic        take;
    logic        is_byte;
    logic        eod;
    logic [7:0]  b;
    logic [1:0]  bpos_inc;
    logic        has_alpha;
    logic        pix_complete;
    logic [7:0]  pb_new [3];
    logic [31:0] color_new;
    logic        run_go;
    logic        lit_pix;
    logic        runpix_done;
    logic        pixel;
    logic [7:0]  left_dec;
    logic [15:0] row_flip;
    logic        col_wrap;
    logic        row_wrap;
    logic        done;
    logic        refused;
    logic        early;
    logic        emit;

    // shared decode of the item at the head of the queue
    always_comb
    begin
        q_ready      = res_ready || !res_valid_reg;
        take         = q_valid && q_ready;
        is_byte      = (q_item.kind != tga_pkg::KIND_RUN_REQ);
        eod          = (q_item.kind == tga_pkg::KIND_LAST_BYTE);
        b            = q_item.data_byte;
        bpos_inc     = bpos_reg + 2'd1;
        has_alpha    = (cfg.bytes_per_pixel == tga_pkg::BPP_ALPHA);
        pix_complete = (bpos_inc == 2'd0) || (!has_alpha && (bpos_inc == 2'd3));
        for (int i = 0; i < 3; i++)
        begin
            pb_new[i] = (bpos_reg == 2'(i)) ? b : pix_reg[i];
        end
        color_new = {(has_alpha ? b : tga_pkg::ALPHA_OPAQUE), pb_new[2], pb_new[1], pb_new[0]};
        run_go      = !is_byte && (phase_reg == tga_pkg::PH_RUN) && (left_reg != 8'd0);
        lit_pix     = is_byte && (phase_reg == tga_pkg::PH_LITERAL) && pix_complete;
        runpix_done = is_byte && (phase_reg == tga_pkg::PH_RUNPIX) && pix_complete;
        pixel       = run_go || lit_pix;
        left_dec    = left_reg - 8'd1;
        row_flip    = cfg.top_origin ? row_reg : (cfg.image_height - 16'd1 - row_reg);
        col_wrap    = ({1'b0, col_reg} + 17'd1) >= {1'b0, cfg.image_width};
        row_wrap    = ({1'b0, row_reg} + 17'd1) >= {1'b0, cfg.image_height};
        done        = pixel && col_wrap && row_wrap;
        refused     = is_byte && (phase_reg == tga_pkg::PH_RUN);
        early       = is_byte && eod && !done && (phase_reg != tga_pkg::PH_RUN) && !runpix_done;
        emit        = pixel || refused || early;

        res_comb.color  = pixel ? (run_go ? run_color_reg : color_new) : 32'd0;
        res_comb.row    = pixel ? row_flip : 16'd0;
        res_comb.col    = pixel ? col_reg : 16'd0;
        res_comb.done   = done;
        if (refused)
        begin
            res_comb.status = tga_pkg::ST_REFUSED;
        end
        else if (early)
        begin
            res_comb.status = tga_pkg::ST_EARLY;
        end
        else
        begin
            res_comb.status = tga_pkg::ST_PIXEL;
        end
    end

    // packet phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                tga_pkg::PH_HEADER:
                begin
                    if (is_byte)
                    begin
                        phase_next = b[7] ? tga_pkg::PH_RUNPIX : tga_pkg::PH_LITERAL;
                    end
                end
                tga_pkg::PH_LITERAL:
                begin
                    if (lit_pix && (left_dec == 8'd0))
                    begin
                        phase_next = tga_pkg::PH_HEADER;
                    end
                end
                tga_pkg::PH_RUNPIX:
                begin
                    if (runpix_done)
                    begin
                        phase_next = tga_pkg::PH_RUN;
                    end
                end
                tga_pkg::PH_RUN:
                begin
                    if (run_go && (left_dec == 8'd0))
                    begin
                        phase_next = tga_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = tga_pkg::PH_HEADER;
                end
            endcase
            if (done)
            begin
                phase_next = tga_pkg::PH_HEADER;
            end
        end
    end

    // counters, pixel bytes and run color
    always_comb
    begin
        left_next      = left_reg;
        bpos_next      = bpos_reg;
        run_color_next = run_color_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        for (int i = 0; i < 3; i++)
        begin
            pix_next[i] = pix_reg[i];
        end
        if (take)
        begin
            if (is_byte && (phase_reg == tga_pkg::PH_HEADER))
            begin
                left_next = b[7] ? (b - tga_pkg::RUN_BIAS) : (b + 8'd1);
                bpos_next = 2'd0;
            end
            else if (is_byte && (phase_reg != tga_pkg::PH_RUN))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pix_next[i] = pb_new[i];
                end
                bpos_next = pix_complete ? 2'd0 : bpos_inc;
                if (lit_pix)
                begin
                    left_next = left_dec;
                end
                if (runpix_done)
                begin
                    run_color_next = color_new;
                end
            end
            else if (run_go)
            begin
                left_next = left_dec;
            end

            if (pixel)
            begin
                if (col_wrap)
                begin
                    col_next = 16'd0;
                    row_next = row_wrap ? 16'd0 : (row_reg + 16'd1);
                end
                else
                begin
                    col_next = col_reg + 16'd1;
                end
            end
            if (done)
            begin
                left_next = 8'd0;
                bpos_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tga_pkg::PH_HEADER;
            left_reg      <= 8'd0;
            bpos_reg      <= 2'd0;
            run_color_reg <= 32'd0;
            col_reg       <= 16'd0;
            row_reg       <= 16'd0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pix_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            bpos_reg      <= bpos_next;
            run_color_reg <= run_color_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            for (int i = 0; i < 3; i++)
            begin
                pix_reg[i] <= pix_next[i];
            end
            if (q_ready)
            begin
                res_valid_reg <= take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= res_comb;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/tga_addr.sv =====
// output stage: frame-store address multiply and output register
// depends on tga_pkg
module tga_addr (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       image_width,
    input  logic              res_valid,
    output logic              res_ready,
    input  tga_pkg::result_t  res,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_color,
    output logic [31:0]       m_addr,
    output logic [1:0]        m_status,
    output logic              m_done
);

    logic        valid_reg;
    logic [31:0] color_reg;
    logic [31:0] addr_reg;
    logic [1:0]  status_reg;
    logic        done_reg;
    logic [31:0] addr_next;

    // row * width + column, always fits in 32 bits
    assign addr_next = ({16'd0, res.row} * {16'd0, image_width}) + {16'd0, res.col};
    assign res_ready = m_ready || !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            color_reg  <= res.color;
            addr_reg   <= addr_next;
            status_reg <= res.status;
            done_reg   <= res.done;
        end
    end

    assign m_valid  = valid_reg;
    assign m_color  = color_reg;
    assign m_addr   = addr_reg;
    assign m_status = status_reg;
    assign m_done   = done_reg;

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder.sv =====
// tga run-length pixel decoder top level; uses tga_pkg, tga_front, tga_back, tga_addr
// a result passes the front queue slot, the tga_back result register and the tga_addr
//   output register before it is valid on the master side
// throughput: one word per cycle, bytes and run requests alike; a 2-entry front queue
//   and the result and output registers let either side stall on its own
// reset: rst_n asynchronous active low clears decoder state and counters and returns
//   the config regs to their reset values
module tga_rle_pixel_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // stream input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    input  logic        s_tlast,   // end_of_data
    // pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] pixel_color, [63:32] pixel_address
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // image_done
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tga_pkg::cfg_t    cfg_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    logic             q_valid;
    logic             q_ready;
    tga_pkg::item_t   q_item;

    logic             res_valid;
    logic             res_ready;
    tga_pkg::result_t res;

    logic [31:0]      out_color;
    logic [31:0]      out_addr;

    // register file: written in the apb access cycle, no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= tga_pkg::WIDTH_RESET;
            cfg_reg.image_height    <= tga_pkg::HEIGHT_RESET;
            cfg_reg.bytes_per_pixel <= tga_pkg::BPP_RESET;
            cfg_reg.top_origin      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                tga_pkg::REG_WIDTH:  cfg_reg.image_width     <= pwdata[15:0];
                tga_pkg::REG_HEIGHT: cfg_reg.image_height    <= pwdata[15:0];
                tga_pkg::REG_BPP:    cfg_reg.bytes_per_pixel <= pwdata[2:0];
                tga_pkg::REG_ORIGIN: cfg_reg.top_origin      <= pwdata[0];
                default:             cfg_reg.top_origin      <= cfg_reg.top_origin;
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (cfg_idx)
            tga_pkg::REG_WIDTH:  prdata = {16'd0, cfg_reg.image_width};
            tga_pkg::REG_HEIGHT: prdata = {16'd0, cfg_reg.image_height};
            tga_pkg::REG_BPP:    prdata = {29'd0, cfg_reg.bytes_per_pixel};
            tga_pkg::REG_ORIGIN: prdata = {31'd0, cfg_reg.top_origin};
            default:             prdata = 32'd0;
        endcase
    end

    // front: tags each word as byte, last byte or run request and queues it
    tga_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_func  (s_tuser),
        .s_byte  (s_tdata),
        .s_last  (s_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: packet state machine, one queued word per cycle while its result register can drain
    tga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // address multiply and output register
    tga_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (cfg_reg.image_width),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_color     (out_color),
        .m_addr      (out_addr),
        .m_status    (m_tuser),
        .m_done      (m_tlast)
    );

    assign m_tdata = {out_addr, out_color};

endmodule

// ===== hw/rtl/tga_checker.sv =====
// port-level checks for the tga run-length pixel decoder
// depends on tga_pkg; bound to tga_rle_pixel_decoder
module tga_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // a refused byte carries no pixel
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == tga_pkg::ST_REFUSED)) |-> (m_tdata == 64'd0 && !m_tlast))
        else $error("refused byte result carries data");

    // image end only on a plain written pixel
    a_done_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == tga_pkg::ST_PIXEL))
        else $error("image done with non-pixel status");

    // no unused status code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == tga_pkg::ST_PIXEL || m_tuser == tga_pkg::ST_EARLY ||
                      m_tuser == tga_pkg::ST_REFUSED))
        else $error("unknown status code");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind tga_rle_pixel_decoder tga_checker u_tga_checker (.*);

// ===== sim/tga_rle_pixel_decoder_tb.sv =====
// self-checking testbench for the tga run-length pixel decoder
// depends on tga_pkg and tga_rle_pixel_decoder; a scoreboard class tracks the decoder
// state and expected pixel words, plain tasks drive the stream and apb ports
module tga_rle_pixel_decoder_tb;

    // stream word kinds carried in s_tuser
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_RUN_PIXEL = 1'b1;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASE_WORDS  = 175;

    // one expected or observed pixel word
    typedef struct {
        logic [tga_pkg::COLOR_W-1:0] color;
        logic [tga_pkg::ADDR_W-1:0]  addr;
        logic [tga_pkg::STAT_W-1:0]  status;
        logic                        done;
    } pixel_word_t;

    // tracks decoder state and holds the pixel words still due
    class pixel_scoreboard;
        logic [tga_pkg::DIM_W-1:0]   image_width;
        logic [tga_pkg::DIM_W-1:0]   image_height;
        logic [tga_pkg::BPP_W-1:0]   bytes_per_pixel;
        logic                        top_origin;

        tga_pkg::phase_t             pkt_phase;
        logic [tga_pkg::BYTE_W-1:0]  pixels_left;
        logic [1:0]                  byte_pos;
        logic [tga_pkg::BYTE_W-1:0]  held [3];
        logic [tga_pkg::COLOR_W-1:0] run_color;
        logic [tga_pkg::DIM_W-1:0]   col;
        logic [tga_pkg::DIM_W-1:0]   row;

        pixel_word_t        due_q[$];
        int unsigned        errors, checked, early_ends, refused, images;

        function new();
            image_width     = tga_pkg::WIDTH_RESET;
            image_height    = tga_pkg::HEIGHT_RESET;
            bytes_per_pixel = tga_pkg::BPP_RESET;
            top_origin      = 1'b0;
            pkt_phase       = tga_pkg::PH_HEADER;
            pixels_left     = '0;
            byte_pos        = '0;
            foreach (held[i])
                held[i] = '0;
            run_color = '0;
            col       = '0;
            row       = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                tga_pkg::REG_WIDTH:  image_width = val[tga_pkg::DIM_W-1:0];
                tga_pkg::REG_HEIGHT: image_height = val[tga_pkg::DIM_W-1:0];
                tga_pkg::REG_BPP:    bytes_per_pixel = val[tga_pkg::BPP_W-1:0];
                tga_pkg::REG_ORIGIN: top_origin = val[0];
                default:    ;
            endcase
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // write one pixel at the current position and step the counters
        function void place_pixel(logic [tga_pkg::COLOR_W-1:0] color, output pixel_word_t res);
            logic [tga_pkg::DIM_W-1:0] eff_row;
            eff_row    = top_origin ? row : image_height - 16'd1 - row;
            res.color  = color;
            res.addr   = 32'(eff_row) * 32'(image_width) + 32'(col);
            res.status = tga_pkg::ST_PIXEL;
            res.done   = 1'b0;
            // counts at or past the limits wrap like a normal row or image end
            if (32'(col) + 1 >= 32'(image_width))
            begin
                col = '0;
                if (32'(row) + 1 >= 32'(image_height))
                begin
                    row      = '0;
                    res.done = 1'b1;
                end
                else
                    row = row + 16'd1;
            end
            else
                col = col + 16'd1;
            // image finished: drop the rest of the packet
            if (res.done)
            begin
                pkt_phase   = tga_pkg::PH_HEADER;
                pixels_left = '0;
                byte_pos    = '0;
            end
        endfunction

        function void note_word(logic func, logic [tga_pkg::BYTE_W-1:0] b, logic eod);
            pixel_word_t res;
            int unsigned nbytes;
            bit          produced;
            logic [7:0]  alpha;
            nbytes   = (bytes_per_pixel == tga_pkg::BPP_ALPHA) ? 4 : 3;
            produced = 1'b0;
            res      = '{'0, '0, tga_pkg::ST_PIXEL, 1'b0};
            if (func == OP_RUN_PIXEL)
            begin
                // run request with no run pending does nothing
                if (pkt_phase != tga_pkg::PH_RUN || pixels_left == 0)
                    return;
                pixels_left = pixels_left - 8'd1;
                if (pixels_left == 0)
                    pkt_phase = tga_pkg::PH_HEADER;
                place_pixel(run_color, res);
                due_q.push_back(res);
                return;
            end
            // a byte while run pixels are pending is refused
            if (pkt_phase == tga_pkg::PH_RUN)
            begin
                res.status = tga_pkg::ST_REFUSED;
                due_q.push_back(res);
                return;
            end
            if (pkt_phase == tga_pkg::PH_HEADER)
            begin
                // top bit set marks a run packet
                if (!b[7])
                begin
                    pixels_left = b + 8'd1;
                    pkt_phase   = tga_pkg::PH_LITERAL;
                end
                else
                begin
                    pixels_left = b - tga_pkg::RUN_BIAS;
                    pkt_phase   = tga_pkg::PH_RUNPIX;
                end
                byte_pos = '0;
            end
            else
            begin
                if (byte_pos < 2'd3)
                    held[byte_pos] = b;
                byte_pos = byte_pos + 2'd1;
                if (byte_pos == 0 || byte_pos >= nbytes)
                begin
                    alpha    = (nbytes == 4) ? b : tga_pkg::ALPHA_OPAQUE;
                    byte_pos = '0;
                    if (pkt_phase == tga_pkg::PH_LITERAL)
                    begin
                        pixels_left = pixels_left - 8'd1;
                        if (pixels_left == 0)
                            pkt_phase = tga_pkg::PH_HEADER;
                        place_pixel({alpha, held[2], held[1], held[0]}, res);
                        produced = 1'b1;
                    end
                    else
                    begin
                        run_color = {alpha, held[2], held[1], held[0]};
                        pkt_phase = tga_pkg::PH_RUN;
                    end
                end
            end
            // stream ends while the decoder still wants bytes
            if (eod && !res.done && pkt_phase != tga_pkg::PH_RUN)
            begin
                if (!produced)
                    res = '{'0, '0, tga_pkg::ST_EARLY, 1'b0};
                else
                    res.status = tga_pkg::ST_EARLY;
                produced = 1'b1;
            end
            if (produced)
                due_q.push_back(res);
        endfunction

        function bit same(string field, logic [31:0] want, logic [31:0] got);
            if (got === want)
                return 1'b1;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
            return 1'b0;
        endfunction

        function void check_result(logic [tga_pkg::COLOR_W-1:0] color,
                                   logic [tga_pkg::ADDR_W-1:0] addr,
                                   logic [tga_pkg::STAT_W-1:0] status, logic done);
            pixel_word_t want;
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual color %h address %h",
                         $time, color, addr);
                $display("%0t: unexpected word status %0d done %0b", $time, status, done);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            void'(same("pixel_color", want.color, color));
            void'(same("pixel_address", want.addr, addr));
            void'(same("status", 32'(want.status), 32'(status)));
            void'(same("image_done", 32'(want.done), 32'(done)));
            if (want.status == tga_pkg::ST_EARLY)
                early_ends++;
            if (want.status == tga_pkg::ST_REFUSED)
                refused++;
            if (want.done)
                images++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] data_byte
    logic        s_tuser = 1'b0;  // [0] func
    logic        s_tlast = 1'b0;  // end_of_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [31:0] pixel_color, [63:32] pixel_address
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;         // image_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard sb = new();

    int unsigned idle_pct  = 0;   // chance per cycle that the sender holds off
    int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned cycle_count = 0;
    int unsigned words_sent = 0;
    int unsigned settings = 0;

    tga_rle_pixel_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // pixel side: check each accepted word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one apb transfer: setup cycle, access cycle, then a bus idle cycle
    task automatic bus_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_expect(logic [1:0] idx, logic [31:0] want);
        logic [31:0] rd;
        bus_access(1'b0, idx, '0, rd);
        if (rd !== want)
        begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, want, rd);
            sb.errors++;
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] rd;
        bus_access(1'b1, idx, val, rd);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_config(logic [15:0] w, logic [15:0] h, logic [2:0] bpp, logic top);
        reg_write(tga_pkg::REG_WIDTH, 32'(w));
        reg_write(tga_pkg::REG_HEIGHT, 32'(h));
        reg_write(tga_pkg::REG_BPP, 32'(bpp));
        reg_write(tga_pkg::REG_ORIGIN, 32'(top));
        reg_expect(tga_pkg::REG_WIDTH, 32'(w));
        reg_expect(tga_pkg::REG_HEIGHT, 32'(h));
        reg_expect(tga_pkg::REG_BPP, 32'(bpp));
        reg_expect(tga_pkg::REG_ORIGIN, 32'(top));
        settings++;
    endtask

    // offer one word, with random hold-off first, and wait for it to be taken
    task automatic send_word(logic func, logic [7:0] b, logic eod);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        s_tlast  <= eod;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(func, b, eod);
        words_sent++;
    endtask

    // drop valid and wait until every pixel word is back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // choose the next word from the tracked decoder state: mostly well-formed
    // packets with random content, a little noise
    task automatic pick_word(output logic f, output logic [7:0] b, output logic e,
                             output bit counted);
        int unsigned roll;
        int unsigned hdr;
        roll    = $urandom_range(99);
        hdr     = $urandom_range(39);
        f       = OP_BYTE;
        b       = 8'($urandom_range(255));
        e       = ($urandom_range(99) < 3);
        counted = 1'b1;
        if (roll < 6)
        begin
            // noise: stray run requests, refused bytes, packets out of step
            f       = 1'($urandom_range(1));
            counted = !(f == OP_RUN_PIXEL && sb.pkt_phase != tga_pkg::PH_RUN);
        end
        else if (sb.pkt_phase == tga_pkg::PH_RUN)
        begin
            f = OP_RUN_PIXEL;
            e = 1'($urandom_range(1));
        end
        else if (sb.pkt_phase == tga_pkg::PH_HEADER)
        begin
            // mostly short packets, long ones now and then
            if (hdr == 0)
                b = 8'($urandom_range(127));
            else if (hdr == 1)
                b = 8'($urandom_range(255, 128));
            else if (hdr < 21)
                b = 8'($urandom_range(3));
            else
                b = 8'd128 + 8'($urandom_range(3));
        end
    endtask

    task automatic run_random(int unsigned n);
        logic        f;
        logic [7:0]  b;
        logic        e;
        bit          counted;
        int unsigned sent;
        sent = 0;
        while (sent < n)
        begin
            pick_word(f, b, e, counted);
            send_word(f, b, e);
            if (counted)
                sent++;
        end
    endtask

    // directed words on a 2x2 image with 3-byte pixels, flipped rows
    task automatic run_directed();
        send_word(OP_RUN_PIXEL, 8'hFF, 1'b1);  // run request with nothing pending
        send_word(OP_BYTE, 8'h00, 1'b0);       // literal packet, one pixel
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b0);
        send_word(OP_BYTE, 8'h80, 1'b0);
        send_word(OP_BYTE, 8'hFF, 1'b0);       // longest run packet
        send_word(OP_BYTE, 8'h11, 1'b0);
        send_word(OP_BYTE, 8'h22, 1'b0);
        send_word(OP_BYTE, 8'h33, 1'b0);
        send_word(OP_BYTE, 8'h55, 1'b0);       // refused, run still pending
        send_word(OP_RUN_PIXEL, 8'h00, 1'b1);  // end flag ignored on run requests
        send_word(OP_RUN_PIXEL, 8'hAA, 1'b0);
        send_word(OP_RUN_PIXEL, 8'h00, 1'b0);  // last pixel, rest of run dropped
        send_word(OP_RUN_PIXEL, 8'h00, 1'b0);  // no run left after image end
        send_word(OP_BYTE, 8'h7F, 1'b1);       // early end right after a header
        send_word(OP_BYTE, 8'h01, 1'b0);
        send_word(OP_BYTE, 8'h02, 1'b1);       // early end inside a pixel
        send_word(OP_BYTE, 8'h03, 1'b1);       // early end on a finished pixel
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers come up at their reset values
        reg_expect(tga_pkg::REG_WIDTH, 32'(tga_pkg::WIDTH_RESET));
        reg_expect(tga_pkg::REG_HEIGHT, 32'(tga_pkg::HEIGHT_RESET));
        reg_expect(tga_pkg::REG_BPP, 32'(tga_pkg::BPP_RESET));
        reg_expect(tga_pkg::REG_ORIGIN, 32'd0);

        apply_config(16'd2, 16'd2, 3'd3, 1'b0);
        run_directed();

        for (int p = 0; p < 8; p++)
        begin
            settle();
            // geometry changes leave counters past the new limits on purpose
            case (p)
                0: apply_config(16'd1, 16'd1, 3'd4, 1'b1);
                1: apply_config(16'd65535, 16'd65535, 3'd3, 1'b0);
                2: apply_config(16'd5, 16'd3, 3'd4, 1'b0);
                3: apply_config(16'd3, 16'd65535, 3'd3, 1'b1);
                4: apply_config(16'd65535, 16'd1, 3'd4, 1'b0);
                default: apply_config(16'($urandom_range(8, 1)), 16'($urandom_range(6, 1)),
                                      3'($urandom_range(4, 3)), 1'($urandom_range(1)));
            endcase
            // idling: none, sender, receiver, both lightly
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            run_random(PHASE_WORDS);
        end
        settle();

        $display("run covered %0d words under %0d register settings and four idling modes",
                 words_sent, settings);
        $display("checked %0d pixel words: %0d images, %0d early ends, %0d refused bytes",
                 sb.checked, sb.images, sb.early_ends, sb.refused);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tga_pkg.sv
hw/rtl/tga_front.sv
hw/rtl/tga_back.sv
hw/rtl/tga_addr.sv
hw/rtl/tga_rle_pixel_decoder.sv
hw/rtl/tga_checker.sv
sim/tga_rle_pixel_decoder_tb.sv
